FILE: rtl/core/spq_pkg.sv
// types, codes and defaults shared by the sorted priority queue
package spq_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned IdW          = 32;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned OccW         = 7;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;

  typedef enum logic [1:0] {
    OpNone,
    OpInsert,
    OpRemove
  } spq_op_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef struct packed {
    spq_op_e op;
    entry_t  ent;
  } ctrl_t;

endpackage

FILE: rtl/core/spq_cell.sv
// one slot of the sorted shift chain
module spq_cell import spq_pkg::*; (
  input  logic   clk_i,
  input  ctrl_t  ctrl_i,
  input  logic   occ_i,
  input  logic   left_occ_i,
  input  logic   left_shift_i,
  input  entry_t left_ent_i,
  input  entry_t right_ent_i,
  output logic   shift_o,
  output entry_t ent_o
);

  entry_t ent_q, ent_d;

  // entry moves right when the new key sorts strictly before it
  assign shift_o = occ_i && (ctrl_i.ent.key < ent_q.key);
  assign ent_o   = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      OpInsert: begin
        if (left_shift_i) begin
          ent_d = left_ent_i;
        end else if (shift_o || (!occ_i && left_occ_i)) begin
          ent_d = ctrl_i.ent;
        end
      end
      OpRemove: begin
        ent_d = right_ent_i;
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// sorted priority queue: top level with occupancy control and result register
//
// usage:
//   a command beat is taken at a rising edge with start high and busy low.
//   command_i selects insert or remove; payload_id_i and sort_key_i are the
//   entry to insert and are ignored on remove.
//   the result beat appears in the cycle after the command for exactly one cycle, marked by
//   valid_o: status, the removed entry, occupancy and the head after the
//   operation. the receiver cannot stall; it must take each result beat.
//   throughput is one command per cycle and busy is always low: every slot
//   of the shift chain compares against the new key and moves at once,
//   so the work of an item is a single chain update.
//   equal keys leave in arrival order. an insert into a full queue returns
//   the full status, a remove from an empty queue the empty status; neither
//   changes the contents.
//   reset empties the queue and drops any pending result beat; slot contents
//   are left as they are and are never shown until written.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [IdW-1:0]     payload_id_i,
  input  logic [KeyW-1:0]    sort_key_i,
  output logic               valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [IdW-1:0]     removed_id_o,
  output logic [KeyW-1:0]    removed_key_o,
  output logic [OccW-1:0]    occupancy_o,
  output logic               head_valid_o,
  output logic [IdW-1:0]     head_id_o,
  output logic [KeyW-1:0]    head_key_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0]    count_q, count_d;
  logic               valid_q;
  logic [StatusW-1:0] status_q, status_d;
  entry_t             removed_q, removed_d;

  logic   accept;
  logic   is_full, is_empty;
  ctrl_t  ctrl;
  entry_t ent   [QUEUE_DEPTH];
  logic   shift [QUEUE_DEPTH];
  logic   occ   [QUEUE_DEPTH];
  logic [CntW+OccW-1:0] count_ext;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_q == CntFull);
  assign is_empty = (count_q == '0);

  always_comb begin
    ctrl.ent.id  = payload_id_i;
    ctrl.ent.key = sort_key_i;
    ctrl.op      = OpNone;
    count_d      = count_q;
    status_d     = StDone;
    removed_d    = '0;
    if (accept) begin
      if (command_i == CmdInsert) begin
        if (is_full) begin
          status_d = StFull;
        end else begin
          ctrl.op = OpInsert;
          count_d = count_q + 1'b1;
        end
      end else begin
        if (is_empty) begin
          status_d = StEmpty;
        end else begin
          ctrl.op   = OpRemove;
          count_d   = count_q - 1'b1;
          removed_d = ent[0];
        end
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i] = (CntW'(i) < count_q);
    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[i]),
      .left_occ_i   ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
      .left_shift_i ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i-1]),
      .left_ent_i   (ent[(i == 0) ? 0 : i-1]),
      .right_ent_i  (ent[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .shift_o      (shift[i]),
      .ent_o        (ent[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  assign count_ext = {{OccW{1'b0}}, count_q};

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign removed_id_o  = removed_q.id;
  assign removed_key_o = removed_q.key;
  assign occupancy_o   = count_ext[OccW-1:0];
  assign head_valid_o  = !is_empty;
  assign head_id_o     = is_empty ? '0 : ent[0].id;
  assign head_key_o    = is_empty ? '0 : ent[0].key;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("occupancy above queue depth");

  a_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("accepted command without result beat");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == StFull) |-> is_full)
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == StEmpty) |-> (is_empty && !head_valid_o))
    else $error("empty status with entries held");
`endif

endmodule
